// ----- sv/lifn_pkg.sv -----
// Shared types and constants for the leaky integrate-and-fire neuron update block.
// Used by lifn_front, lifn_back and lif_neuron_update; depends on nothing else.

package lifn_pkg;

	localparam int NEURONS   = 1024;
	localparam int MAX_WRAPS = 15;

	localparam int NEURON_AW = $clog2(NEURONS);
	localparam int WRAP_W    = $clog2(MAX_WRAPS + 1);

	localparam int INDEX_W = 10;
	localparam int POT_W   = 32;
	localparam int STEP_W  = 32;
	localparam int DECAY_W = 16;
	localparam int REFR_W  = 16;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LEVEL      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_STEPS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_MODE       = 3'd4;

	// Reset-mode codes.
	localparam logic MODE_SET_LEVEL   = 1'b0;
	localparam logic MODE_SUBTRACT    = 1'b1;

	// One input word; the neuron index sits in the lowest bits.
	typedef struct packed {
		logic        [STEP_W-1:0]  sim_step;
		logic signed [POT_W-1:0]   synaptic_increment;
		logic        [INDEX_W-1:0] neuron_index;
	} lifn_item_t;

	// One result word; the echoed index sits in the lowest bits.
	typedef struct packed {
		logic                      wrap_fault;
		logic signed [POT_W-1:0]   new_potential;
		logic                      was_refractory;
		logic                      spiked;
		logic        [INDEX_W-1:0] out_index;
	} lifn_result_t;

	typedef struct packed {
		logic        [DECAY_W-1:0] decay_factor;
		logic signed [POT_W-1:0]   threshold_level;
		logic signed [POT_W-1:0]   reset_level;
		logic        [REFR_W-1:0]  refractory_steps;
		logic                      reset_mode;
	} lifn_cfg_t;

endpackage

// ----- sv/lif_neuron_update.sv -----
// Top level of the leaky integrate-and-fire neuron update block.
// Depends on lifn_pkg, lifn_front and lifn_back.
//
// Each input word names one neuron of a population of 1024, carries a signed
// Q16.16 synaptic increment and the current time step. The block reads the
// neuron's stored potential, last spike step and spike flag and, unless the
// neuron is refractory, decays and integrates the potential, tests it against
// the threshold and applies the chosen reset rule; it then writes the neuron
// back. Exactly one result word leaves for each input word, in order.
// Input words wait in a two-entry queue, so the sender can run ahead while the
// update engine works. The engine handles one neuron at a time, stepping from
// leaving the queue to the result register through the memory read, the
// multiplier stage, the add and saturate stage, the threshold test and the
// write-back. In subtract mode a wrap state subtracts the threshold gap while
// the potential is above the threshold; past MAX_WRAPS subtractions it faults.
// After reset the engine clears the state memory, one neuron per cycle, for all
// 1024 neurons; s_tready stays low during that pass. Configuration writes are
// taken at any time and should only be made while the block is idle.
// When the receiver holds m_tready low the result stays in its register and
// the engine waits; the queue keeps taking words until it is full.

module lif_neuron_update (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lifn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lifn_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// neuron_index [9:0], synaptic_increment [41:10], sim_step [73:42], zero [79:74]
	input  logic [lifn_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_index [9:0], spiked [10], was_refractory [11], new_potential [43:12],
	// wrap_fault [44], zero [47:45]
	output logic [lifn_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	lifn_pkg::lifn_cfg_t    cfg_q;
	lifn_pkg::lifn_item_t   q_item;
	lifn_pkg::lifn_result_t result;
	logic                   q_valid;
	logic                   q_pop;
	logic                   clearing;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_factor     <= 16'hFFFF;
			cfg_q.threshold_level  <= 32'sh0001_0000;
			cfg_q.reset_level      <= '0;
			cfg_q.refractory_steps <= '0;
			cfg_q.reset_mode       <= lifn_pkg::MODE_SET_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				lifn_pkg::REG_DECAY_FACTOR:
					cfg_q.decay_factor <= cfg_data[lifn_pkg::DECAY_W-1:0];
				lifn_pkg::REG_THRESHOLD_LEVEL:
					cfg_q.threshold_level <= cfg_data[lifn_pkg::POT_W-1:0];
				lifn_pkg::REG_RESET_LEVEL:
					cfg_q.reset_level <= cfg_data[lifn_pkg::POT_W-1:0];
				lifn_pkg::REG_REFRACTORY_STEPS:
					cfg_q.refractory_steps <= cfg_data[lifn_pkg::REFR_W-1:0];
				lifn_pkg::REG_RESET_MODE:
					cfg_q.reset_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	lifn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.hold     (clearing),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	lifn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_result (result)
	);

	// The result word is packed from its lowest field up; spare bits are zero.
	assign m_tdata = {(lifn_pkg::OUT_TDATA_W - $bits(lifn_pkg::lifn_result_t))'(0), result};

endmodule

// ----- sv/lifn_front.sv -----
// Front end of the neuron update block: accepts input words into a two-entry queue.
// Depends on lifn_pkg for the input word type.

module lifn_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lifn_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                hold,
	output logic                                q_valid,
	output lifn_pkg::lifn_item_t                q_item,
	input  logic                                q_pop
);

	lifn_pkg::lifn_item_t slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;

	// No words are taken while the state memory is being cleared.
	assign s_tready = !hold && (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= lifn_pkg::lifn_item_t'(s_tdata[$bits(lifn_pkg::lifn_item_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/lifn_back.sv -----
// Back end of the neuron update block: state memory, update sequencer and result register.
// Depends on lifn_pkg for types, sizes and reset-mode codes.

module lifn_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lifn_pkg::lifn_cfg_t    cfg,
	input  logic                   q_valid,
	input  lifn_pkg::lifn_item_t   q_item,
	output logic                   q_pop,
	output logic                   clearing,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output lifn_pkg::lifn_result_t m_result
);

	localparam int WORD_W = 1 + lifn_pkg::STEP_W + lifn_pkg::POT_W;
	localparam int PROD_W = lifn_pkg::POT_W + lifn_pkg::DECAY_W + 1;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_ADD    = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_WRAP   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} lifn_state_t;

	// Memory word: bit 64 has spiked, bits 63:32 last spike step, bits 31:0 potential.
	logic [WORD_W-1:0] mem [lifn_pkg::NEURONS];
	logic [WORD_W-1:0] rd_data_q;

	lifn_state_t                       state_q;
	logic [lifn_pkg::NEURON_AW-1:0]    clr_q;
	lifn_pkg::lifn_item_t              item_q;
	logic signed [lifn_pkg::POT_W-1:0] pot_q;
	logic [lifn_pkg::STEP_W-1:0]       last_q;
	logic                              hs_q;
	logic                              frozen_q;
	logic signed [PROD_W-1:0]          prod_q;
	logic signed [lifn_pkg::POT_W-1:0] v_q;
	logic signed [lifn_pkg::POT_W:0]   gap_q;
	logic                              spiked_q;
	logic                              fault_q;
	logic [lifn_pkg::WRAP_W-1:0]       n_q;
	logic                              m_valid_q;
	lifn_pkg::lifn_result_t            out_q;

	logic                              out_free;
	logic                              mem_we;
	logic [lifn_pkg::NEURON_AW-1:0]    mem_wa;
	logic [WORD_W-1:0]                 mem_wd;
	logic [lifn_pkg::NEURON_AW-1:0]    mem_ra;
	logic signed [lifn_pkg::POT_W-1:0] rd_pot;
	logic [lifn_pkg::STEP_W-1:0]       rd_last;
	logic                              rd_hs;
	logic [lifn_pkg::STEP_W-1:0]       since;
	logic                              frozen;
	logic signed [lifn_pkg::POT_W+1:0] sum;
	logic signed [lifn_pkg::POT_W-1:0] sat;
	logic signed [lifn_pkg::POT_W+1:0] wrapped;
	logic                              above;

	assign out_free = !m_valid_q || m_tready;
	assign clearing = (state_q == ST_CLEAR);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign m_tvalid = m_valid_q;
	assign m_result = out_q;

	assign mem_ra  = q_item.neuron_index[lifn_pkg::NEURON_AW-1:0];
	assign mem_we  = (state_q == ST_CLEAR) || ((state_q == ST_DONE) && out_free);
	assign mem_wa  = (state_q == ST_CLEAR) ? clr_q
	               : item_q.neuron_index[lifn_pkg::NEURON_AW-1:0];
	assign mem_wd  = (state_q == ST_CLEAR) ? '0
	               : {hs_q | spiked_q, spiked_q ? item_q.sim_step : last_q, v_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	assign rd_pot  = rd_data_q[lifn_pkg::POT_W-1:0];
	assign rd_last = rd_data_q[lifn_pkg::POT_W +: lifn_pkg::STEP_W];
	assign rd_hs   = rd_data_q[WORD_W-1];

	// A neuron that has never fired is never frozen.
	assign since  = item_q.sim_step - rd_last;
	assign frozen = rd_hs && ((item_q.sim_step < rd_last) ||
	                (since <= {{(lifn_pkg::STEP_W-lifn_pkg::REFR_W){1'b0}},
	                           cfg.refractory_steps}));

	// The arithmetic shift of the product is the floor of the Q16.16 result.
	assign sum = (lifn_pkg::POT_W+2)'(prod_q >>> 16)
	           + (lifn_pkg::POT_W+2)'(item_q.synaptic_increment);

	always_comb begin
		if (sum[lifn_pkg::POT_W+1:lifn_pkg::POT_W-1] == 3'b000 ||
		    sum[lifn_pkg::POT_W+1:lifn_pkg::POT_W-1] == 3'b111) begin
			sat = sum[lifn_pkg::POT_W-1:0];
		end else if (sum[lifn_pkg::POT_W+1]) begin
			sat = {1'b1, {(lifn_pkg::POT_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(lifn_pkg::POT_W-1){1'b1}}};
		end
	end

	assign above   = (v_q > cfg.threshold_level);
	assign wrapped = (lifn_pkg::POT_W+2)'(v_q) - (lifn_pkg::POT_W+2)'(gap_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
			end
			ST_MUL: begin
				pot_q    <= rd_pot;
				last_q   <= rd_last;
				hs_q     <= rd_hs;
				frozen_q <= frozen;
				prod_q   <= rd_pot * $signed({1'b0, cfg.decay_factor});
				spiked_q <= 1'b0;
				fault_q  <= 1'b0;
			end
			ST_ADD: begin
				v_q   <= frozen_q ? pot_q : sat;
				gap_q <= (lifn_pkg::POT_W+1)'(cfg.threshold_level)
				       - (lifn_pkg::POT_W+1)'(cfg.reset_level);
			end
			ST_DECIDE: begin
				n_q <= '0;
				if (!frozen_q && above) begin
					spiked_q <= 1'b1;
					if (cfg.reset_mode == lifn_pkg::MODE_SET_LEVEL) begin
						v_q <= cfg.reset_level;
					end else if (gap_q <= 0) begin
						v_q     <= cfg.reset_level;
						fault_q <= 1'b1;
					end
				end
			end
			ST_WRAP: begin
				if (above) begin
					if (n_q == lifn_pkg::WRAP_W'(lifn_pkg::MAX_WRAPS)) begin
						v_q     <= cfg.reset_level;
						fault_q <= 1'b1;
					end else begin
						v_q <= wrapped[lifn_pkg::POT_W-1:0];
						n_q <= n_q + 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.out_index      <= item_q.neuron_index;
					out_q.spiked         <= spiked_q;
					out_q.was_refractory <= frozen_q;
					out_q.new_potential  <= v_q;
					out_q.wrap_fault     <= fault_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == lifn_pkg::NEURON_AW'(lifn_pkg::NEURONS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!frozen_q && above &&
					    cfg.reset_mode == lifn_pkg::MODE_SUBTRACT && gap_q > 0) begin
						state_q <= ST_WRAP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WRAP: begin
					if (!above || n_q == lifn_pkg::WRAP_W'(lifn_pkg::MAX_WRAPS)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
